### hdl/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

  // Commands carried by an input beat.
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_WRITE    = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic [2:0] CMD_RELEASE  = 3'd5;
  localparam logic [2:0] CMD_BUS_FREE = 3'd6;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH = 2'd1;

  localparam logic [15:0] DELAY_RST   = 16'd6;
  localparam logic [15:0] STRETCH_RST = 16'd2000;

  // Sequence actions. A loop action carries its jump target in the upper nibble.
  localparam logic [3:0] OP_END     = 4'd0;
  localparam logic [3:0] OP_SDA_REL = 4'd1;
  localparam logic [3:0] OP_SDA_LOW = 4'd2;
  localparam logic [3:0] OP_SCL_LOW = 4'd3;
  localparam logic [3:0] OP_SCL_REL = 4'd4;
  localparam logic [3:0] OP_DLY     = 4'd5;
  localparam logic [3:0] OP_SDA_BIT = 4'd6;
  localparam logic [3:0] OP_SDA_ACK = 4'd7;
  localparam logic [3:0] OP_SMP_ACK = 4'd8;
  localparam logic [3:0] OP_SMP_BIT = 4'd9;
  localparam logic [3:0] OP_LOOP    = 4'd10;

  // What the sequencer is waiting on between ticks.
  localparam logic [1:0] WAIT_NONE    = 2'd0;
  localparam logic [1:0] WAIT_DELAY   = 2'd1;
  localparam logic [1:0] WAIT_STRETCH = 2'd2;

  // Largest number of actions that can run within one tick is five.
  localparam int unsigned EXEC_SLOTS = 6;

  localparam logic [7:0] PROG_START [16] = '{
    {4'd0, OP_SDA_REL}, {4'd0, OP_SCL_REL}, {4'd0, OP_DLY}, {4'd0, OP_SDA_LOW},
    {4'd0, OP_DLY}, {4'd0, OP_SCL_LOW}, {4'd0, OP_DLY}, {4'd0, OP_END},
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  localparam logic [7:0] PROG_STOP [16] = '{
    {4'd0, OP_SDA_LOW}, {4'd0, OP_DLY}, {4'd0, OP_SCL_REL}, {4'd0, OP_DLY},
    {4'd0, OP_SDA_REL}, {4'd0, OP_DLY}, {4'd0, OP_END}, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  localparam logic [7:0] PROG_WRITE [16] = '{
    {4'd0, OP_SDA_BIT}, {4'd0, OP_DLY}, {4'd0, OP_SCL_REL}, {4'd0, OP_DLY},
    {4'd0, OP_SCL_LOW}, {4'd0, OP_LOOP}, {4'd0, OP_SDA_REL}, {4'd0, OP_DLY},
    {4'd0, OP_SCL_REL}, {4'd0, OP_DLY}, {4'd0, OP_SMP_ACK}, {4'd0, OP_SCL_LOW},
    {4'd0, OP_DLY}, {4'd0, OP_END}, 8'd0, 8'd0};

  localparam logic [7:0] PROG_READ [16] = '{
    {4'd0, OP_SDA_REL}, {4'd0, OP_DLY}, {4'd0, OP_SCL_REL}, {4'd0, OP_DLY},
    {4'd0, OP_SMP_BIT}, {4'd0, OP_SCL_LOW}, {4'd1, OP_LOOP}, {4'd0, OP_SDA_ACK},
    {4'd0, OP_DLY}, {4'd0, OP_SCL_REL}, {4'd0, OP_DLY}, {4'd0, OP_SCL_LOW},
    {4'd0, OP_SDA_REL}, {4'd0, OP_DLY}, {4'd0, OP_END}, 8'd0};

  localparam logic [7:0] PROG_RELEASE [16] = '{
    {4'd0, OP_SDA_LOW}, {4'd0, OP_SCL_LOW}, {4'd0, OP_END}, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  localparam logic [7:0] PROG_BUS_FREE [16] = '{
    {4'd0, OP_SDA_REL}, {4'd0, OP_SCL_REL}, {4'd0, OP_END}, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
    logic       scl_in;
  } in_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       stretch_timeout;
  } out_t;

  typedef struct packed {
    logic [2:0]  active_op;
    logic [4:0]  seq_step;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift;
    logic [15:0] dly_cnt;
    logic [15:0] str_cnt;
    logic        scl_drv;
    logic        sda_drv;
    logic        ack_flag;
    logic        to_flag;
    logic        ack_choice;
    logic [1:0]  wait_kind;
    logic [7:0]  rx_hold;
  } seq_state_t;

  function automatic logic [7:0] prog_code(input logic [2:0] op, input logic [3:0] step);
    logic [7:0] code;
    unique case (op)
      CMD_START:    code = PROG_START[step];
      CMD_STOP:     code = PROG_STOP[step];
      CMD_WRITE:    code = PROG_WRITE[step];
      CMD_READ:     code = PROG_READ[step];
      CMD_RELEASE:  code = PROG_RELEASE[step];
      CMD_BUS_FREE: code = PROG_BUS_FREE[step];
      default:      code = {4'd0, OP_END};
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

### hdl/i2c_master_bit_engine.sv
// Each accepted input beat is held in the input register, and its result beat is then
// registered in the result register. Throughput: one tick per cycle unless a result
// is held back by out_ready; the whole tick is evaluated between the input register and
// the result register, and the input register holds one more beat while a result waits.
// Reset (synchronous, active low) releases both lines, idles the sequencer, clears
// all flags and the received byte, and restores delay_ticks 6 and stretch_limit 2000.
`default_nettype none
module i2c_master_bit_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire i2cm_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output i2cm_pkg::out_t                         out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                       cfg_data
);
  import i2cm_pkg::*;

  logic        s1_valid_r;
  in_t         s1_item_r;
  logic        out_valid_r;
  out_t        out_data_r;
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  logic        done_nxt;
  logic [15:0] delay_ticks_r;
  logic [15:0] stretch_limit_r;
  logic        adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  i2cm_exec u_exec (
    .st            (state_r),
    .item          (s1_item_r),
    .delay_ticks   (delay_ticks_r),
    .stretch_limit (stretch_limit_r),
    .st_nxt        (state_nxt),
    .done          (done_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      state_r         <= '0;
      delay_ticks_r   <= DELAY_RST;
      stretch_limit_r <= STRETCH_RST;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_index == REG_DELAY) begin
          delay_ticks_r <= cfg_data;
        end else if (cfg_index == REG_STRETCH) begin
          stretch_limit_r <= cfg_data;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      out_data_r.scl_pull_low    <= state_nxt.scl_drv;
      out_data_r.sda_pull_low    <= state_nxt.sda_drv;
      out_data_r.busy_res        <= (state_nxt.active_op != CMD_NONE);
      out_data_r.done_res        <= done_nxt;
      out_data_r.rx_byte         <= state_nxt.rx_hold;
      out_data_r.ack_seen        <= state_nxt.ack_flag;
      out_data_r.stretch_timeout <= state_nxt.to_flag;
    end
  end

endmodule
`default_nettype wire

### hdl/i2cm_exec.sv
`default_nettype none
module i2cm_exec (
  input  wire i2cm_pkg::seq_state_t st,
  input  wire i2cm_pkg::in_t        item,
  input  wire logic [15:0]          delay_ticks,
  input  wire logic [15:0]          stretch_limit,
  output i2cm_pkg::seq_state_t      st_nxt,
  output logic                      done
);
  import i2cm_pkg::*;

  logic [15:0] dly_load;
  logic [15:0] str_lim;

  assign dly_load = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
  assign str_lim  = (stretch_limit == 16'd0) ? 16'd1 : stretch_limit;

  always_comb begin
    seq_state_t s;
    logic       run;
    logic [7:0] code;
    logic [3:0] op;
    logic [2:0] bit_sel;
    logic [3:0] bc_inc;

    s    = st;
    run  = 1'b0;
    done = 1'b0;
    code = 8'd0;
    op   = OP_END;
    bit_sel = 3'd0;
    bc_inc  = 4'd0;

    // Tick-level bookkeeping: take a command, or advance the pending delay or clock-stretch wait.
    if (s.active_op == CMD_NONE) begin
      if (item.command != CMD_NONE && item.command <= CMD_BUS_FREE) begin
        s.active_op = item.command;
        s.seq_step  = 5'd0;
        s.bit_cnt   = 4'd0;
        s.to_flag   = 1'b0;
        s.wait_kind = WAIT_NONE;
        if (item.command == CMD_WRITE) begin
          s.shift = item.tx_byte;
        end
        if (item.command == CMD_READ) begin
          s.shift      = 8'd0;
          s.ack_choice = item.send_ack;
        end
        run = 1'b1;
      end
    end else if (s.wait_kind == WAIT_DELAY) begin
      s.dly_cnt = s.dly_cnt - 16'd1;
      if (s.dly_cnt == 16'd0) begin
        s.wait_kind = WAIT_NONE;
        run = 1'b1;
      end
    end else if (s.wait_kind == WAIT_STRETCH) begin
      if (item.scl_in) begin
        s.wait_kind = WAIT_NONE;
        run = 1'b1;
      end else begin
        s.str_cnt = s.str_cnt + 16'd1;
        if (s.str_cnt >= str_lim) begin
          s.to_flag   = 1'b1;
          s.wait_kind = WAIT_NONE;
          run = 1'b1;
        end
      end
    end else begin
      run = 1'b1;
    end

    // Zero-time actions chain within the tick until a wait or the end.
    for (int i = 0; i < EXEC_SLOTS; i++) begin
      if (run) begin
        code = prog_code(s.active_op, s.seq_step[3:0]);
        op   = code[3:0];
        s.seq_step = s.seq_step + 5'd1;
        unique case (op)
          OP_SDA_REL: s.sda_drv = 1'b0;
          OP_SDA_LOW: s.sda_drv = 1'b1;
          OP_SCL_LOW: s.scl_drv = 1'b1;
          OP_SDA_BIT: begin
            bit_sel   = 3'd7 - s.bit_cnt[2:0];
            s.sda_drv = ~s.shift[bit_sel];
          end
          OP_SDA_ACK: s.sda_drv = s.ack_choice;
          OP_SMP_ACK: s.ack_flag = ~item.sda_in;
          OP_SMP_BIT: s.shift = {s.shift[6:0], item.sda_in};
          OP_SCL_REL: begin
            s.scl_drv   = 1'b0;
            s.str_cnt   = 16'd0;
            s.wait_kind = WAIT_STRETCH;
            run = 1'b0;
          end
          OP_DLY: begin
            s.dly_cnt   = dly_load;
            s.wait_kind = WAIT_DELAY;
            run = 1'b0;
          end
          OP_LOOP: begin
            bc_inc    = s.bit_cnt + 4'd1;
            s.bit_cnt = bc_inc;
            if (!bc_inc[3]) begin
              s.seq_step = {1'b0, code[7:4]};
            end
          end
          default: begin
            if (s.active_op == CMD_READ) begin
              s.rx_hold = s.shift;
            end
            s.active_op = CMD_NONE;
            s.seq_step  = 5'd0;
            done = 1'b1;
            run  = 1'b0;
          end
        endcase
      end
    end

    st_nxt = s;
  end

endmodule
`default_nettype wire

### tb/i2c_master_bit_engine_tb.sv
`default_nettype none
module i2c_master_bit_engine_tb;
  import i2cm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned RANDOM_TICKS = 25;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef enum logic [3:0] {
    A_END, A_SDA_REL, A_SDA_LOW, A_SCL_LOW, A_SCL_REL, A_DELAY,
    A_SDA_BIT, A_SDA_ACK, A_SMP_ACK, A_SMP_BIT, A_LOOP
  } action_e;

  typedef enum logic [1:0] {W_NONE, W_DELAY, W_STRETCH} wait_e;
  typedef enum logic [1:0] {LVL_LOW, LVL_HIGH, LVL_RAND} level_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DELAY;
  logic [15:0] cfg_data = '0;

  i2c_master_bit_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Bus sequencer as the block should see it after each accepted tick.
  logic [15:0] cfg_delay;
  logic [15:0] cfg_stretch;
  logic [2:0] bus_op;
  logic [4:0] bus_step;
  logic [3:0] bus_bitcnt;
  logic [7:0] bus_shift;
  logic [15:0] bus_dly_left;
  logic [15:0] bus_stretch_cnt;
  logic bus_scl_low;
  logic bus_sda_low;
  logic bus_ack;
  logic bus_timeout;
  logic bus_ack_drive;
  wait_e bus_wait;
  logic [7:0] bus_rx;

  out_t pin_results_q[$];
  logic [2:0] cmd_plan_q[$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic holdoff_req = 1'b0;
  logic holdoff_seen = 1'b0;
  int unsigned holdoff_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void i2c_reset_model();
    cfg_delay = DELAY_RST;
    cfg_stretch = STRETCH_RST;
    bus_op = CMD_NONE;
    bus_step = '0;
    bus_bitcnt = '0;
    bus_shift = '0;
    bus_dly_left = '0;
    bus_stretch_cnt = '0;
    bus_scl_low = 1'b0;
    bus_sda_low = 1'b0;
    bus_ack = 1'b0;
    bus_timeout = 1'b0;
    bus_ack_drive = 1'b0;
    bus_wait = W_NONE;
    bus_rx = '0;
  endfunction

  function automatic action_e seq_action(input logic [2:0] cmd, input logic [3:0] step);
    action_e a;
    a = A_END;
    case (cmd)
      CMD_START: case (step)
        4'd0: a = A_SDA_REL;  4'd1: a = A_SCL_REL;  4'd2: a = A_DELAY;
        4'd3: a = A_SDA_LOW;  4'd4: a = A_DELAY;    4'd5: a = A_SCL_LOW;
        4'd6: a = A_DELAY;    default: a = A_END;
      endcase
      CMD_STOP: case (step)
        4'd0: a = A_SDA_LOW;  4'd1: a = A_DELAY;    4'd2: a = A_SCL_REL;
        4'd3: a = A_DELAY;    4'd4: a = A_SDA_REL;  4'd5: a = A_DELAY;
        default: a = A_END;
      endcase
      CMD_WRITE: case (step)
        4'd0: a = A_SDA_BIT;  4'd1: a = A_DELAY;    4'd2: a = A_SCL_REL;
        4'd3: a = A_DELAY;    4'd4: a = A_SCL_LOW;  4'd5: a = A_LOOP;
        4'd6: a = A_SDA_REL;  4'd7: a = A_DELAY;    4'd8: a = A_SCL_REL;
        4'd9: a = A_DELAY;    4'd10: a = A_SMP_ACK; 4'd11: a = A_SCL_LOW;
        4'd12: a = A_DELAY;   default: a = A_END;
      endcase
      CMD_READ: case (step)
        4'd0: a = A_SDA_REL;  4'd1: a = A_DELAY;    4'd2: a = A_SCL_REL;
        4'd3: a = A_DELAY;    4'd4: a = A_SMP_BIT;  4'd5: a = A_SCL_LOW;
        4'd6: a = A_LOOP;     4'd7: a = A_SDA_ACK;  4'd8: a = A_DELAY;
        4'd9: a = A_SCL_REL;  4'd10: a = A_DELAY;   4'd11: a = A_SCL_LOW;
        4'd12: a = A_SDA_REL; 4'd13: a = A_DELAY;   default: a = A_END;
      endcase
      CMD_RELEASE: case (step)
        4'd0: a = A_SDA_LOW;  4'd1: a = A_SCL_LOW;  default: a = A_END;
      endcase
      CMD_BUS_FREE: case (step)
        4'd0: a = A_SDA_REL;  4'd1: a = A_SCL_REL;  default: a = A_END;
      endcase
      default: a = A_END;
    endcase
    return a;
  endfunction

  function automatic out_t i2c_tick(input in_t t);
    out_t pins;
    action_e act;
    logic run;
    logic done;
    logic [15:0] lim;
    int guard;
    run = 1'b0;
    done = 1'b0;
    if (bus_op == CMD_NONE) begin
      if (t.command >= CMD_START && t.command <= CMD_BUS_FREE) begin
        bus_op = t.command;
        bus_step = '0;
        bus_bitcnt = '0;
        bus_timeout = 1'b0;
        bus_wait = W_NONE;
        if (t.command == CMD_WRITE) bus_shift = t.tx_byte;
        if (t.command == CMD_READ) begin
          bus_shift = '0;
          bus_ack_drive = t.send_ack;
        end
        run = 1'b1;
      end
    end else if (bus_wait == W_DELAY) begin
      bus_dly_left = bus_dly_left - 16'd1;
      if (bus_dly_left == 16'd0) begin
        bus_wait = W_NONE;
        run = 1'b1;
      end
    end else if (bus_wait == W_STRETCH) begin
      if (t.scl_in) begin
        bus_wait = W_NONE;
        run = 1'b1;
      end else begin
        lim = (cfg_stretch == 16'd0) ? 16'd1 : cfg_stretch;
        bus_stretch_cnt = bus_stretch_cnt + 16'd1;
        if (bus_stretch_cnt >= lim) begin
          bus_timeout = 1'b1;
          bus_wait = W_NONE;
          run = 1'b1;
        end
      end
    end else begin
      run = 1'b1;
    end

    // Actions that take no time all run within this tick.
    for (guard = 0; run && guard < 64; guard++) begin
      act = seq_action(bus_op, bus_step[3:0]);
      bus_step = bus_step + 5'd1;
      case (act)
        A_SDA_REL: bus_sda_low = 1'b0;
        A_SDA_LOW: bus_sda_low = 1'b1;
        A_SCL_LOW: bus_scl_low = 1'b1;
        A_SDA_BIT: bus_sda_low = ~bus_shift[3'd7 - bus_bitcnt[2:0]];
        A_SDA_ACK: bus_sda_low = bus_ack_drive;
        A_SMP_ACK: bus_ack = ~t.sda_in;
        A_SMP_BIT: bus_shift = {bus_shift[6:0], t.sda_in};
        A_SCL_REL: begin
          bus_scl_low = 1'b0;
          bus_stretch_cnt = '0;
          bus_wait = W_STRETCH;
          run = 1'b0;
        end
        A_DELAY: begin
          bus_dly_left = (cfg_delay == 16'd0) ? 16'd1 : cfg_delay;
          bus_wait = W_DELAY;
          run = 1'b0;
        end
        A_LOOP: begin
          bus_bitcnt = bus_bitcnt + 4'd1;
          // A write repeats from its data bit; a read skips the SDA release.
          if (bus_bitcnt < 4'd8) bus_step = (bus_op == CMD_WRITE) ? 5'd0 : 5'd1;
        end
        default: begin
          if (bus_op == CMD_READ) bus_rx = bus_shift;
          bus_op = CMD_NONE;
          bus_step = '0;
          done = 1'b1;
          run = 1'b0;
        end
      endcase
    end

    pins.scl_pull_low = bus_scl_low;
    pins.sda_pull_low = bus_sda_low;
    pins.busy_res = (bus_op != CMD_NONE);
    pins.done_res = done;
    pins.rx_byte = bus_rx;
    pins.ack_seen = bus_ack;
    pins.stretch_timeout = bus_timeout;
    return pins;
  endfunction

  function automatic logic drive_level(input level_e l);
    case (l)
      LVL_LOW: return 1'b0;
      LVL_HIGH: return 1'b1;
      default: return 1'($urandom);
    endcase
  endfunction

  function automatic in_t make_tick(input logic [2:0] cmd, input logic [7:0] tx,
                                    input logic ack, input level_e sda, input level_e scl);
    in_t t;
    t.command = cmd;
    t.tx_byte = tx;
    t.send_ack = ack;
    t.sda_in = drive_level(sda);
    t.scl_in = drive_level(scl);
    return t;
  endfunction

  // A transfer as software would issue it: start, one to three bytes, stop; or a lone release or bus-free command.
  function automatic void plan_transfer();
    int unsigned n;
    n = $urandom_range(0, 99);
    if (n < 8) begin
      cmd_plan_q.push_back(CMD_RELEASE);
    end else if (n < 16) begin
      cmd_plan_q.push_back(CMD_BUS_FREE);
    end else begin
      cmd_plan_q.push_back(CMD_START);
      repeat ($urandom_range(1, 3))
        cmd_plan_q.push_back($urandom_range(0, 1) ? CMD_WRITE : CMD_READ);
      cmd_plan_q.push_back(CMD_STOP);
    end
  endfunction

  function automatic in_t random_tick(input int unsigned scl_low_pct);
    in_t t;
    t.tx_byte = 8'($urandom);
    t.send_ack = 1'($urandom);
    t.sda_in = 1'($urandom);
    if (bus_wait == W_STRETCH) t.scl_in = ($urandom_range(0, 99) >= scl_low_pct);
    else t.scl_in = 1'($urandom);
    if (bus_op == CMD_NONE) begin
      if ($urandom_range(0, 99) < 8) begin
        t.command = 3'($urandom);
      end else begin
        if (cmd_plan_q.size() == 0) plan_transfer();
        t.command = cmd_plan_q.pop_front();
      end
    end else begin
      // Commands while busy must be ignored.
      t.command = ($urandom_range(0, 99) < 80) ? CMD_NONE : 3'($urandom);
    end
    return t;
  endfunction

  task automatic send_tick(input in_t t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    pin_results_q.push_back(i2c_tick(t));
  endtask

  task automatic finish_sequence(input level_e sda, input level_e scl);
    while (bus_op != CMD_NONE)
      send_tick(make_tick(CMD_NONE, 8'($urandom), 1'($urandom), sda, scl));
  endtask

  task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx, input logic ack,
                             input level_e sda, input level_e scl);
    send_tick(make_tick(cmd, tx, ack, sda, scl));
    finish_sequence(sda, scl);
  endtask

  task automatic wait_results_in();
    in_valid <= 1'b0;
    do @(posedge clk); while (pin_results_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_DELAY) cfg_delay = val;
    else if (idx == REG_STRETCH) cfg_stretch = val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] delay, input logic [15:0] stretch);
    write_reg(REG_DELAY, delay);
    write_reg(REG_STRETCH, stretch);
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  task automatic test_reset_values();
    send_tick(make_tick(CMD_NONE, 8'h00, 1'b0, LVL_HIGH, LVL_HIGH));
    send_tick(make_tick(CMD_UNUSED, 8'hFF, 1'b1, LVL_LOW, LVL_LOW));
    // A start at the reset delay setting.
    run_command(CMD_START, 8'h00, 1'b0, LVL_RAND, LVL_HIGH);
    wait_results_in();
  endtask

  task automatic test_directed_commands();
    set_config(16'd1, 16'd2000);
    run_command(CMD_START, 8'h00, 1'b0, LVL_RAND, LVL_HIGH);
    run_command(CMD_WRITE, 8'hFF, 1'b0, LVL_LOW, LVL_HIGH);
    run_command(CMD_WRITE, 8'h00, 1'b1, LVL_HIGH, LVL_HIGH);
    send_tick(make_tick(CMD_WRITE, 8'hA5, 1'b0, LVL_RAND, LVL_HIGH));
    send_tick(make_tick(CMD_START, 8'h5A, 1'b1, LVL_RAND, LVL_HIGH));
    send_tick(make_tick(CMD_UNUSED, 8'h3C, 1'b1, LVL_RAND, LVL_HIGH));
    finish_sequence(LVL_RAND, LVL_HIGH);
    run_command(CMD_READ, 8'h00, 1'b1, LVL_HIGH, LVL_HIGH);
    run_command(CMD_READ, 8'hFF, 1'b0, LVL_LOW, LVL_HIGH);
    run_command(CMD_READ, 8'h81, 1'b1, LVL_RAND, LVL_RAND);
    run_command(CMD_STOP, 8'h00, 1'b0, LVL_RAND, LVL_HIGH);
    run_command(CMD_RELEASE, 8'h00, 1'b0, LVL_RAND, LVL_HIGH);
    run_command(CMD_BUS_FREE, 8'h00, 1'b0, LVL_RAND, LVL_HIGH);
    run_command(CMD_START, 8'h00, 1'b0, LVL_RAND, LVL_RAND);
    run_command(CMD_STOP, 8'h00, 1'b0, LVL_RAND, LVL_RAND);
    wait_results_in();
  endtask

  // The slave holds the clock low until every clock-stretch wait times out.
  task automatic test_clock_stretch();
    set_config(16'd1, 16'd4);
    run_command(CMD_BUS_FREE, 8'h00, 1'b0, LVL_RAND, LVL_LOW);
    run_command(CMD_WRITE, 8'h96, 1'b0, LVL_RAND, LVL_LOW);
    run_command(CMD_RELEASE, 8'h00, 1'b0, LVL_RAND, LVL_LOW);
    wait_results_in();
  endtask

  task automatic test_config_extremes();
    set_config(16'd20, 16'hFFFF);
    run_command(CMD_START, 8'h00, 1'b0, LVL_RAND, LVL_HIGH);
    run_command(CMD_BUS_FREE, 8'h00, 1'b0, LVL_RAND, LVL_RAND);
    wait_results_in();
    // Zero in either register must behave as one.
    set_config(16'h0000, 16'h0000);
    run_command(CMD_WRITE, 8'h6B, 1'b0, LVL_RAND, LVL_RAND);
    run_command(CMD_BUS_FREE, 8'h00, 1'b0, LVL_RAND, LVL_LOW);
    run_command(CMD_READ, 8'h00, 1'b1, LVL_RAND, LVL_LOW);
    wait_results_in();
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input logic [15:0] delay, input logic [15:0] stretch,
                                     input int unsigned scl_low_pct);
    int unsigned ticks_done;
    in_t t;
    ticks_done = 0;
    set_config(delay, stretch);
    set_idling(tx_pct, rx_pct);
    while (ticks_done < RANDOM_TICKS) begin
      t = random_tick(scl_low_pct);
      if (bus_op != CMD_NONE || (t.command >= CMD_START && t.command <= CMD_BUS_FREE))
        ticks_done++;
      send_tick(t);
    end
    finish_sequence(LVL_RAND, LVL_HIGH);
    wait_results_in();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    set_config(16'd1, 16'd4);
    set_idling(0, 0);
    holdoff_req <= ~holdoff_req;
    repeat (60) send_tick(random_tick(20));
    finish_sequence(LVL_RAND, LVL_HIGH);
    wait_results_in();
  endtask

  always @(posedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      out_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic string pins_str(input out_t p);
    return $sformatf("scl=%0b sda=%0b busy=%0b done=%0b rx=%02h ack=%0b tmo=%0b",
                     p.scl_pull_low, p.sda_pull_low, p.busy_res, p.done_res,
                     p.rx_byte, p.ack_seen, p.stretch_timeout);
  endfunction

  task automatic check_pins(input out_t exp, input out_t got);
    string bad;
    bad = "";
    if (got.scl_pull_low !== exp.scl_pull_low) bad = {bad, " scl_pull_low"};
    if (got.sda_pull_low !== exp.sda_pull_low) bad = {bad, " sda_pull_low"};
    if (got.busy_res !== exp.busy_res) bad = {bad, " busy_res"};
    if (got.done_res !== exp.done_res) bad = {bad, " done_res"};
    if (got.rx_byte !== exp.rx_byte) bad = {bad, " rx_byte"};
    if (got.ack_seen !== exp.ack_seen) bad = {bad, " ack_seen"};
    if (got.stretch_timeout !== exp.stretch_timeout) bad = {bad, " stretch_timeout"};
    if (bad != "") begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: mismatch in%s: expected %s, got %s",
                 $time, bad, pins_str(exp), pins_str(got));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pin_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected, got %s",
                   $time, pins_str(out_data));
      end else begin
        check_pins(pin_results_q.pop_front(), out_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pin_results_q.size());
      $display("i2c_master_bit_engine regression: fail");
      $finish;
    end
  end

  initial begin
    i2c_reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed_commands();
    test_clock_stretch();
    test_config_extremes();
    test_random_traffic(0, 0, 16'd1, 16'd1, 40);
    test_random_traffic(84, 0, 16'd2, 16'd3, 30);
    test_random_traffic(0, 84, 16'd3, 16'd500, 30);
    test_random_traffic(36, 36, 16'd0, 16'd0, 30);
    test_backpressure();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pin_results_q.size() == 0) begin
      $display("i2c_master_bit_engine regression: pass");
    end else begin
      $display("i2c_master_bit_engine regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
